/* rtl/hashed_lru_block_cache_tags_top_defines.svh */
// Assertion macros shared by the cache tag engine.
`ifndef HASHED_LRU_BLOCK_CACHE_TAGS_TOP_DEFINES_SVH
`define HASHED_LRU_BLOCK_CACHE_TAGS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HLC_ASSERT_IMPL(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error("assertion failed");
`define HLC_ASSERT_NEXT(label, clk_s, rst_s, cond, conseq) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> (conseq)) else $error("assertion failed");
`else
`define HLC_ASSERT_IMPL(label, clk_s, rst_s, prop)
`define HLC_ASSERT_NEXT(label, clk_s, rst_s, cond, conseq)
`endif
`endif

/* rtl/hlc_pkg.sv */
// Package with types, codes and the bucket hash of the cache tag engine.
`timescale 1ns / 1ps
`default_nettype none
package hlc_pkg;
    localparam logic [1:0] ACT_GET = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_PIN = 2'd2;
    localparam logic [1:0] ACT_UNPIN = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;
    localparam logic [31:0] TIME_NONE = 32'hffffffff;
    localparam int HASH_SHIFT = 16;
    localparam logic [7:0] COUNT_MAX = 8'hff;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  entry;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] entry_out;
        logic       was_hit;
        logic       needs_read;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_RANK,
        S_DONE
    } state_t;

    function automatic logic [31:0] hash_key(input logic [7:0] dev, input logic [31:0] blk);
        hash_key = ({24'd0, dev} << HASH_SHIFT) ^ blk;
    endfunction
endpackage
`default_nettype wire

/* rtl/hlc_mod_unit.sv */
// Remainder unit: reciprocal multiplication, then back-subtraction.
`timescale 1ns / 1ps
`default_nettype none
module hlc_mod_unit
    import hlc_pkg::*;
#(
    parameter int NUM_BUCKETS = 13
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] value,
    output logic             busy,
    output logic [6:0]       rem
);
    localparam int SHIFT_L = $clog2(NUM_BUCKETS);
    localparam logic [32:0] MAGIC =
        33'(((65'd1 << (32 + SHIFT_L)) / 65'(NUM_BUCKETS)) + 65'd1);
    localparam logic [31:0] DIVISOR = 32'(NUM_BUCKETS);
    logic [31:0] val_reg, val_next;
    logic [64:0] prod_reg, prod_next;
    logic [6:0]  rem_reg, rem_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] quot;
    logic [31:0] diff;

    always_comb
    begin
        val_next = val_reg;
        prod_next = prod_reg;
        rem_next = rem_reg;
        phase_next = phase_reg;
        quot = 32'(prod_reg >> (32 + SHIFT_L));
        diff = val_reg - quot * DIVISOR;
        if (start)
        begin
            val_next = value;
            phase_next = 2'd2;
        end
        else if (phase_reg == 2'd2)
        begin
            prod_next = 65'(val_reg) * 65'(MAGIC);
            phase_next = 2'd1;
        end
        else if (phase_reg == 2'd1)
        begin
            rem_next = diff[6:0];
            phase_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            val_reg <= '0;
            prod_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            val_reg <= val_next;
            prod_reg <= prod_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = (phase_reg != 2'd0);
    assign rem = rem_reg;
endmodule
`default_nettype wire

/* rtl/hashed_lru_block_cache_tags_top.sv */
// Top level of the cache tag engine: sequencer, entry state and scan.
// A release, pin or unpin goes through S_DONE, which raises its result. A get runs
// the bucket hash in S_HASH, scans all NUM_ENTRIES entries in S_SCAN, then updates
// the chosen entry and raises its result in S_RANK. No new request of any kind
// is taken until the result of the last one has been taken.
// Reset clears all tags, counts and times and sets ranks to count minus one minus index.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_lru_block_cache_tags_top_defines.svh"
module hashed_lru_block_cache_tags_top
    import hlc_pkg::*;
#(
    parameter int NUM_ENTRIES = 32,
    parameter int NUM_BUCKETS = 13
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire req_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output rsp_t      out_data
);
    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int RW = $clog2(NUM_ENTRIES);

    logic [7:0]    tdev_reg  [NUM_ENTRIES];
    logic [31:0]   tblk_reg  [NUM_ENTRIES];
    logic [7:0]    cnt_reg   [NUM_ENTRIES];
    logic [31:0]   luse_reg  [NUM_ENTRIES];
    logic          dval_reg  [NUM_ENTRIES];
    logic [RW-1:0] rank_reg  [NUM_ENTRIES];
    logic [6:0]    bkt_reg   [NUM_ENTRIES];

    state_t state_reg, state_next;
    req_t   req_reg;
    rsp_t   rsp_reg;
    logic   out_valid_reg;
    logic [IW:0] idx_reg;
    logic [6:0] tb_reg;
    logic       mod_phase_reg;
    logic       hit_reg, bf_reg, of_reg;
    logic [IW-1:0] hit_i_reg, bf_i_reg, of_i_reg;
    logic [6:0] of_b_reg;
    logic       mod_start, mod_busy;
    logic [6:0] mod_rem;
    logic [31:0] mod_val;
    logic [IW-1:0] cur;
    logic       eidx_ok;
    logic [IW-1:0] eidx;

    hlc_mod_unit #(.NUM_BUCKETS(NUM_BUCKETS)) u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start), .value(mod_val),
        .busy(mod_busy), .rem(mod_rem)
    );

    assign cur = idx_reg[IW-1:0];
    assign eidx_ok = ({27'd0, in_data.entry} < 32'(NUM_ENTRIES));
    assign eidx = IW'(req_reg.entry);
    assign mod_val = hash_key(req_reg.device, req_reg.block_number);
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        mod_start = 1'b0;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                    state_next = (in_data.action == ACT_GET) ? S_HASH : S_DONE;
            S_HASH:
                if (!mod_phase_reg)
                    mod_start = 1'b1;
                else if (!mod_busy)
                    state_next = S_SCAN;
            S_SCAN:
                if (idx_reg == (IW+1)'(NUM_ENTRIES - 1))
                    state_next = S_RANK;
            S_RANK:
                if (idx_reg == (IW+1)'(NUM_ENTRIES))
                    state_next = S_IDLE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            mod_phase_reg <= 1'b0;
            idx_reg <= '0;
            req_reg <= '0;
            rsp_reg <= '0;
            tb_reg <= '0;
            hit_reg <= 1'b0;
            bf_reg <= 1'b0;
            of_reg <= 1'b0;
            hit_i_reg <= '0;
            bf_i_reg <= '0;
            of_i_reg <= '0;
            of_b_reg <= '0;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                tdev_reg[i] <= '0;
                tblk_reg[i] <= '0;
                cnt_reg[i] <= '0;
                luse_reg[i] <= '0;
                dval_reg[i] <= 1'b0;
                rank_reg[i] <= RW'(NUM_ENTRIES - 1 - i);
                bkt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        req_reg <= in_data;
                        mod_phase_reg <= 1'b0;
                        idx_reg <= '0;
                        hit_reg <= 1'b0;
                        bf_reg <= 1'b0;
                        of_reg <= 1'b0;
                        rsp_reg <= {((in_data.action != ACT_GET && !eidx_ok) ?
                                     ST_NO_FREE : ST_OK), 5'd0, 1'b0, 1'b0};
                    end
                S_HASH:
                    if (!mod_phase_reg)
                        mod_phase_reg <= 1'b1;
                    else if (!mod_busy)
                        tb_reg <= mod_rem;
                S_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (bkt_reg[cur] == tb_reg && tdev_reg[cur] == req_reg.device &&
                        tblk_reg[cur] == req_reg.block_number &&
                        (!hit_reg || rank_reg[cur] < rank_reg[hit_i_reg]))
                    begin
                        hit_reg <= 1'b1;
                        hit_i_reg <= cur;
                    end
                    if (cnt_reg[cur] == 8'd0 && bkt_reg[cur] == tb_reg &&
                        (!bf_reg || rank_reg[cur] < rank_reg[bf_i_reg]))
                    begin
                        bf_reg <= 1'b1;
                        bf_i_reg <= cur;
                    end
                    if (cnt_reg[cur] == 8'd0 && luse_reg[cur] != TIME_NONE &&
                        (!of_reg || luse_reg[cur] < luse_reg[of_i_reg] ||
                         (luse_reg[cur] == luse_reg[of_i_reg] &&
                          (bkt_reg[cur] < of_b_reg || (bkt_reg[cur] == of_b_reg &&
                           rank_reg[cur] < rank_reg[of_i_reg])))))
                    begin
                        of_reg <= 1'b1;
                        of_i_reg <= cur;
                        of_b_reg <= bkt_reg[cur];
                    end
                end
                S_RANK:
                begin
                    if (idx_reg == (IW+1)'(NUM_ENTRIES - 1) + 1'b1)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        out_valid_reg <= 1'b1;
                        if (hit_reg)
                        begin
                            rsp_reg.entry_out <= 5'(hit_i_reg);
                            rsp_reg.was_hit <= 1'b1;
                            if (cnt_reg[hit_i_reg] == COUNT_MAX)
                                rsp_reg.status <= ST_OVERFLOW;
                            else
                            begin
                                cnt_reg[hit_i_reg] <= cnt_reg[hit_i_reg] + 8'd1;
                                luse_reg[hit_i_reg] <= req_reg.now;
                                rsp_reg.needs_read <= !dval_reg[hit_i_reg];
                                dval_reg[hit_i_reg] <= 1'b1;
                            end
                        end
                        else if (bf_reg || of_reg)
                        begin
                            rsp_reg.entry_out <= 5'(bf_reg ? bf_i_reg : of_i_reg);
                            rsp_reg.needs_read <= 1'b1;
                            for (int i = 0; i < NUM_ENTRIES; i++)
                                if (rank_reg[i] < rank_reg[bf_reg ? bf_i_reg : of_i_reg])
                                    rank_reg[i] <= rank_reg[i] + 1'b1;
                            rank_reg[bf_reg ? bf_i_reg : of_i_reg] <= '0;
                            tdev_reg[bf_reg ? bf_i_reg : of_i_reg] <= req_reg.device;
                            tblk_reg[bf_reg ? bf_i_reg : of_i_reg] <= req_reg.block_number;
                            bkt_reg[bf_reg ? bf_i_reg : of_i_reg] <= tb_reg;
                            cnt_reg[bf_reg ? bf_i_reg : of_i_reg] <= 8'd1;
                            luse_reg[bf_reg ? bf_i_reg : of_i_reg] <= req_reg.now;
                            dval_reg[bf_reg ? bf_i_reg : of_i_reg] <= 1'b1;
                        end
                        else
                            rsp_reg.status <= ST_NO_FREE;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    if (rsp_reg.status == ST_OK)
                    begin
                        if (req_reg.action == ACT_PIN)
                        begin
                            if (cnt_reg[eidx] == COUNT_MAX)
                                rsp_reg.status <= ST_OVERFLOW;
                            else
                                cnt_reg[eidx] <= cnt_reg[eidx] + 8'd1;
                        end
                        else if (cnt_reg[eidx] == 8'd0)
                            rsp_reg.status <= ST_UNDERFLOW;
                        else
                        begin
                            cnt_reg[eidx] <= cnt_reg[eidx] - 8'd1;
                            if (req_reg.action == ACT_RELEASE && cnt_reg[eidx] == 8'd1)
                                luse_reg[eidx] <= req_reg.now;
                        end
                    end
                end
                default:
                    ;
            endcase
        end
    end

    `HLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `HLC_ASSERT_IMPL(a_busy_no_ready, clk, rst_n, (state_reg != S_IDLE) |-> !in_ready)
    `HLC_ASSERT_IMPL(a_scan_in_range, clk, rst_n,
        (state_reg == S_SCAN) |-> (idx_reg < (IW+1)'(NUM_ENTRIES)))
endmodule
`default_nettype wire
